/* rtl/psdb_pkg.sv */
// shared types, constants and datapath helpers for the steer/drive bias pipeline
// used by psdb_root_pipe and pd_steer_drive_bias_core; no dependencies
package psdb_pkg;

    // pipeline shape
    localparam int NSTG     = 14;   // register stages from input word to output word
    localparam int SQRT_STG = 8;    // root stages, two result bits each

    // fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SQ_W       = 32; // sum of two quartered squares
    localparam int ROOT_W     = 16;
    localparam int SUM_W      = 23; // bias sums before clipping
    localparam int WIDE_W     = 36; // common width for truncating shifts

    // truncating divide amounts
    localparam logic [3:0] STEER_SHIFT   = 4'd14;
    localparam logic [3:0] GYRO_SHIFT    = 4'd10;
    localparam logic [3:0] DRIVE_P_SHIFT = 4'd14;
    localparam logic [3:0] DRIVE_D_SHIFT = 4'd12;  // times 4 over 16384

    // register reset values
    localparam logic signed [15:0] STEER_GAIN_P_RST = 16'sd3000;
    localparam logic signed [15:0] STEER_GAIN_D_RST = 16'sd0;
    localparam logic [14:0]        STEER_LIMIT_RST  = 15'd600;
    localparam logic signed [15:0] YAW_DAMP_RST     = 16'sd0;
    localparam logic signed [15:0] DRIVE_GAIN_P_RST = 16'sd1500;
    localparam logic signed [15:0] DRIVE_GAIN_D_RST = 16'sd0;
    localparam logic [14:0]        DRIVE_LIMIT_RST  = 15'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEER_GAIN_P = 3'd0,
        REG_STEER_GAIN_D = 3'd1,
        REG_STEER_LIMIT  = 3'd2,
        REG_YAW_DAMP     = 3'd3,
        REG_DRIVE_GAIN_P = 3'd4,
        REG_DRIVE_GAIN_D = 3'd5,
        REG_DRIVE_LIMIT  = 3'd6
    } cfg_reg_t;

    // partial remainder and root accumulator of the digit-by-digit square root
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] acc;
    } root_t;

    // divide by four, truncating toward zero
    function automatic logic signed [15:0] quarter(input logic signed [17:0] a);
        logic signed [17:0] t;
        t = a[17] ? (a + 18'sd3) : a;
        return signed'(t[17:2]);
    endfunction

    // divide by 2**sh, truncating toward zero
    function automatic logic signed [WIDE_W-1:0] div_pow2(
        input logic signed [WIDE_W-1:0] x,
        input logic [3:0]               sh
    );
        logic signed [WIDE_W-1:0] bias;
        bias = x[WIDE_W-1] ? ((36'sd1 <<< sh) - 36'sd1) : 36'sd0;
        return (x + bias) >>> sh;
    endfunction

    // symmetric clip to +-lim
    function automatic logic signed [15:0] clip_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [14:0]             lim
    );
        logic signed [SUM_W-1:0] l;
        logic signed [SUM_W-1:0] l_neg;
        logic signed [SUM_W-1:0] r;
        l     = signed'({8'b0, lim});
        l_neg = -l;
        if (v > l)
        begin
            r = l;
        end
        else if (v < l_neg)
        begin
            r = l_neg;
        end
        else
        begin
            r = v;
        end
        return signed'(r[15:0]);
    endfunction

    // one iteration of the root, trial bit 4**k
    function automatic root_t sqrt_step(input root_t cur, input logic [3:0] k);
        logic [SQ_W:0] bit_v;
        logic [SQ_W:0] trial;
        root_t         nxt;
        bit_v = 33'd1 << {k, 1'b0};
        trial = {1'b0, cur.acc} + bit_v;
        if ({1'b0, cur.rem} >= trial)
        begin
            nxt.rem = cur.rem - trial[SQ_W-1:0];
            nxt.acc = (cur.acc >> 1) + bit_v[SQ_W-1:0];
        end
        else
        begin
            nxt.rem = cur.rem;
            nxt.acc = cur.acc >> 1;
        end
        return nxt;
    endfunction

endpackage

/* rtl/pd_steer_drive_bias_core.sv */
// an accepted input word passes through the 14 register stages to its output word
// throughput: one word per cycle while out_stall is low; stages advance independently so bubbles
// close up under output stall, and input stall rises only when all 14 are full
// reset: stage valid bits clear, config registers return to their defaults
// depends on psdb_pkg and psdb_root_pipe
module pd_steer_drive_bias_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // config
    input  logic                                  cfg_we,
    input  logic [psdb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psdb_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  target_valid,
    input  logic signed [17:0]                    target_angle,
    input  logic signed [17:0]                    angle_rate,
    input  logic signed [17:0]                    pos_x,
    input  logic signed [17:0]                    pos_y,
    input  logic signed [17:0]                    vel_x,
    input  logic signed [17:0]                    vel_y,
    input  logic signed [15:0]                    wanted_depth,
    input  logic                                  gyro_present,
    input  logic signed [15:0]                    gyro_rate,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  result_valid,
    output logic signed [15:0]                    steer_corr,
    output logic signed [15:0]                    drive_corr,
    output logic [15:0]                           target_range,
    output logic [15:0]                           target_speed
);
    import psdb_pkg::*;

    // stage map: 0 products, 1 sums, 2..9 roots, 10 range error,
    // 11 drive products, 12 drive sum, 13 clip and output
    localparam int S_ROOT0 = 2;
    localparam int S_ERR   = S_ROOT0 + SQRT_STG;
    localparam int S_DPROD = S_ERR + 1;
    localparam int S_DSUM  = S_DPROD + 1;
    localparam int S_OUT   = S_DSUM + 1;

    // config registers
    logic signed [15:0] steer_gain_p_reg;
    logic signed [15:0] steer_gain_d_reg;
    logic [14:0]        steer_limit_reg;
    logic signed [15:0] yaw_damp_reg;
    logic signed [15:0] drive_gain_p_reg;
    logic signed [15:0] drive_gain_d_reg;
    logic [14:0]        drive_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_gain_p_reg <= STEER_GAIN_P_RST;
            steer_gain_d_reg <= STEER_GAIN_D_RST;
            steer_limit_reg  <= STEER_LIMIT_RST;
            yaw_damp_reg     <= YAW_DAMP_RST;
            drive_gain_p_reg <= DRIVE_GAIN_P_RST;
            drive_gain_d_reg <= DRIVE_GAIN_D_RST;
            drive_limit_reg  <= DRIVE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEER_GAIN_P: steer_gain_p_reg <= signed'(cfg_data);
                REG_STEER_GAIN_D: steer_gain_d_reg <= signed'(cfg_data);
                REG_STEER_LIMIT:  steer_limit_reg  <= cfg_data[14:0];
                REG_YAW_DAMP:     yaw_damp_reg     <= signed'(cfg_data);
                REG_DRIVE_GAIN_P: drive_gain_p_reg <= signed'(cfg_data);
                REG_DRIVE_GAIN_D: drive_gain_d_reg <= signed'(cfg_data);
                REG_DRIVE_LIMIT:  drive_limit_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or its word moves on
    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   load;

    always_comb
    begin
        load[NSTG] = !out_stall;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            load[i] = !v_reg[i] || load[i+1];
        end
    end

    assign in_stall = !load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (load[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // side fields that ride along
    logic               tv_reg    [S_OUT];
    logic signed [15:0] depth_reg [S_ERR];
    logic               gp_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            tv_reg[0]    <= target_valid;
            depth_reg[0] <= wanted_depth;
            gp_reg       <= gyro_present;
        end
        for (int i = 1; i < S_OUT; i++)
        begin
            if (load[i])
            begin
                tv_reg[i] <= tv_reg[i-1];
            end
        end
        for (int i = 1; i < S_ERR; i++)
        begin
            if (load[i])
            begin
                depth_reg[i] <= depth_reg[i-1];
            end
        end
    end

    // stage 0: quarter and square, steer products
    logic signed [15:0] qpx, qpy, qvx, qvy;
    logic [SQ_W-1:0]    sq_px_reg, sq_py_reg, sq_vx_reg, sq_vy_reg;
    logic signed [33:0] prod_p_reg, prod_d_reg;
    logic signed [31:0] prod_g_reg;

    assign qpx = quarter(pos_x);
    assign qpy = quarter(pos_y);
    assign qvx = quarter(vel_x);
    assign qvy = quarter(vel_y);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            sq_px_reg  <= SQ_W'(qpx) * SQ_W'(qpx);
            sq_py_reg  <= SQ_W'(qpy) * SQ_W'(qpy);
            sq_vx_reg  <= SQ_W'(qvx) * SQ_W'(qvx);
            sq_vy_reg  <= SQ_W'(qvy) * SQ_W'(qvy);
            prod_p_reg <= 34'(steer_gain_p_reg) * 34'(target_angle);
            prod_d_reg <= 34'(steer_gain_d_reg) * 34'(angle_rate);
            prod_g_reg <= yaw_damp_reg * gyro_rate;
        end
    end

    // stage 1: sums of squares, steer sum
    logic [SQ_W-1:0]          pos_sum_reg, vel_sum_reg;
    logic signed [WIDE_W-1:0] st_full;
    logic signed [SUM_W-1:0]  steer_reg [1:S_DSUM];

    always_comb
    begin
        st_full = -div_pow2(WIDE_W'(prod_p_reg), STEER_SHIFT)
                  - div_pow2(WIDE_W'(prod_d_reg), STEER_SHIFT);
        if (gp_reg)
        begin
            st_full = st_full - div_pow2(WIDE_W'(prod_g_reg), GYRO_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            pos_sum_reg  <= sq_px_reg + sq_py_reg;
            vel_sum_reg  <= sq_vx_reg + sq_vy_reg;
            steer_reg[1] <= signed'(st_full[SUM_W-1:0]);
        end
        for (int i = 2; i <= S_DSUM; i++)
        begin
            if (load[i])
            begin
                steer_reg[i] <= steer_reg[i-1];
            end
        end
    end

    // stages 2..9: square roots
    logic [ROOT_W-1:0] range_root, speed_root;

    psdb_root_pipe u_range_root (
        .clk      (clk),
        .load     (load[S_ERR-1:S_ROOT0]),
        .radicand (pos_sum_reg),
        .root     (range_root)
    );

    psdb_root_pipe u_speed_root (
        .clk      (clk),
        .load     (load[S_ERR-1:S_ROOT0]),
        .radicand (vel_sum_reg),
        .root     (speed_root)
    );

    // stage 10: range error; range and speed carried to the output
    logic signed [18:0] dep4;
    logic signed [18:0] err_reg;
    logic [ROOT_W-1:0]  range_reg [S_ERR:S_DSUM];
    logic [ROOT_W-1:0]  speed_reg [S_ERR:S_DSUM];

    assign dep4 = signed'({depth_reg[S_ERR-1][15], depth_reg[S_ERR-1], 2'b00});

    always_ff @(posedge clk)
    begin
        if (load[S_ERR])
        begin
            err_reg          <= dep4 - signed'({3'b000, range_root});
            range_reg[S_ERR] <= range_root;
            speed_reg[S_ERR] <= speed_root;
        end
        for (int i = S_ERR + 1; i <= S_DSUM; i++)
        begin
            if (load[i])
            begin
                range_reg[i] <= range_reg[i-1];
                speed_reg[i] <= speed_reg[i-1];
            end
        end
    end

    // stage 11: drive products
    logic signed [34:0] prod_dp_reg;
    logic signed [32:0] prod_dd_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_DPROD])
        begin
            prod_dp_reg <= 35'(drive_gain_p_reg) * 35'(err_reg);
            prod_dd_reg <= 33'(drive_gain_d_reg) * 33'(signed'({1'b0, speed_reg[S_DPROD-1]}));
        end
    end

    // stage 12: drive sum
    logic signed [WIDE_W-1:0] dr_full;
    logic signed [SUM_W-1:0]  drive_reg;

    assign dr_full = div_pow2(WIDE_W'(prod_dp_reg), DRIVE_P_SHIFT)
                     - div_pow2(WIDE_W'(prod_dd_reg), DRIVE_D_SHIFT);

    always_ff @(posedge clk)
    begin
        if (load[S_DSUM])
        begin
            drive_reg <= signed'(dr_full[SUM_W-1:0]);
        end
    end

    // stage 13: clip, zero the word for an invalid target
    logic               result_valid_reg;
    logic signed [15:0] steer_corr_reg, drive_corr_reg;
    logic [15:0]        target_range_reg, target_speed_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_OUT])
        begin
            result_valid_reg <= tv_reg[S_OUT-1];
            if (tv_reg[S_OUT-1])
            begin
                steer_corr_reg   <= clip_sym(steer_reg[S_DSUM], steer_limit_reg);
                drive_corr_reg   <= clip_sym(drive_reg, drive_limit_reg);
                target_range_reg <= range_reg[S_DSUM];
                target_speed_reg <= speed_reg[S_DSUM];
            end
            else
            begin
                steer_corr_reg   <= '0;
                drive_corr_reg   <= '0;
                target_range_reg <= '0;
                target_speed_reg <= '0;
            end
        end
    end

    assign out_valid    = v_reg[NSTG-1];
    assign result_valid = result_valid_reg;
    assign steer_corr   = steer_corr_reg;
    assign drive_corr   = drive_corr_reg;
    assign target_range = target_range_reg;
    assign target_speed = target_speed_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg) && out_stall)
        else $error("input stalled while the pipeline has room");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
        else $error("accepted word missing from first stage");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |-> steer_corr == 16'sd0 && drive_corr == 16'sd0
            && target_range == 16'd0 && target_speed == 16'd0)
        else $error("invalid target word carries nonzero fields");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> target_range <= 16'd46340 && target_speed <= 16'd46340)
        else $error("root out of range");

endmodule

/* rtl/psdb_root_pipe.sv */
// pipelined floor square root of a 32-bit radicand, two result bits per stage
// depends on psdb_pkg; stage loads come from the parent's pipeline control
module psdb_root_pipe (
    input  logic                              clk,
    input  logic [psdb_pkg::SQRT_STG-1:0]     load,
    input  logic [psdb_pkg::SQ_W-1:0]         radicand,
    output logic [psdb_pkg::ROOT_W-1:0]       root
);
    import psdb_pkg::*;

    root_t stg_reg  [SQRT_STG];
    root_t stg_next [SQRT_STG];

    for (genvar s = 0; s < SQRT_STG; s++)
    begin : g_stg
        root_t cur;

        if (s == 0)
        begin : g_first
            assign cur = '{rem: radicand, acc: '0};
        end
        else
        begin : g_rest
            assign cur = stg_reg[s-1];
        end

        // trial bits 4**(15-2s) then 4**(14-2s)
        assign stg_next[s] = sqrt_step(sqrt_step(cur, 4'(2*(SQRT_STG-s)-1)),
                                       4'(2*(SQRT_STG-s)-2));

        always_ff @(posedge clk)
        begin
            if (load[s])
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign root = stg_reg[SQRT_STG-1].acc[ROOT_W-1:0];

endmodule

/* verif/pd_steer_drive_bias_core_tb.sv */
// self-checking testbench for pd_steer_drive_bias_core: PD steer/drive bias with range and speed
// depends on psdb_pkg (register codes, reset values) and the core RTL
module pd_steer_drive_bias_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psdb_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 20;
    localparam logic [2:0] REG_UNUSED  = 3'd7;  // no register at this index

    typedef struct {
        logic               target_valid;
        logic signed [17:0] target_angle;
        logic signed [17:0] angle_rate;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic signed [17:0] vel_x;
        logic signed [17:0] vel_y;
        logic signed [15:0] wanted_depth;
        logic               gyro_present;
        logic signed [15:0] gyro_rate;
    } sample_t;

    typedef struct {
        logic               result_valid;
        logic signed [15:0] steer_corr;
        logic signed [15:0] drive_corr;
        logic [15:0]        target_range;
        logic [15:0]        target_speed;
    } bias_t;

    typedef struct {
        logic signed [15:0] steer_gain_p;
        logic signed [15:0] steer_gain_d;
        logic [14:0]        steer_limit;
        logic signed [15:0] yaw_damp;
        logic signed [15:0] drive_gain_p;
        logic signed [15:0] drive_gain_d;
        logic [14:0]        drive_limit;
    } bias_cfg_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               target_valid;
    logic signed [17:0] target_angle;
    logic signed [17:0] angle_rate;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] vel_x;
    logic signed [17:0] vel_y;
    logic signed [15:0] wanted_depth;
    logic               gyro_present;
    logic signed [15:0] gyro_rate;
    logic               out_valid;
    logic               out_stall;
    logic               result_valid;
    logic signed [15:0] steer_corr;
    logic signed [15:0] drive_corr;
    logic [15:0]        target_range;
    logic [15:0]        target_speed;

    bias_cfg_t cfg_mirror;
    bias_t     bias_q[$];
    int        fail_count;
    int        cycle_cnt;
    int        stall_left;
    bit        send_burst;
    bit        recv_burst;

    pd_steer_drive_bias_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target_valid (target_valid),
        .target_angle (target_angle),
        .angle_rate   (angle_rate),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .wanted_depth (wanted_depth),
        .gyro_present (gyro_present),
        .gyro_rate    (gyro_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_valid (result_valid),
        .steer_corr   (steer_corr),
        .drive_corr   (drive_corr),
        .target_range (target_range),
        .target_speed (target_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint isqrt_floor(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // quarter each component, truncating toward zero, then take the floor root
    function automatic longint quarter_hypot(input logic signed [17:0] a,
                                             input logic signed [17:0] b);
        longint qa;
        longint qb;
        qa = longint'(a) / 4;
        qb = longint'(b) / 4;
        return isqrt_floor(qa * qa + qb * qb);
    endfunction

    function automatic longint clamp_bias(input longint v, input logic [14:0] lim);
        longint l;
        l = longint'({1'b0, lim});
        if (v > l)
            return l;
        if (v < -l)
            return -l;
        return v;
    endfunction

    function automatic bias_t predict_bias(input sample_t s);
        bias_t  r;
        longint steer;
        longint drive;
        longint rng;
        longint spd;
        r = '{1'b0, 16'sd0, 16'sd0, 16'd0, 16'd0};
        if (!s.target_valid)
            return r;
        steer = (longint'(cfg_mirror.steer_gain_p) * (0 - longint'(s.target_angle))) / 16384;
        steer += (-longint'(cfg_mirror.steer_gain_d) * longint'(s.angle_rate)) / 16384;
        if (s.gyro_present)
            steer += (-longint'(cfg_mirror.yaw_damp) * longint'(s.gyro_rate)) / 1024;
        steer = clamp_bias(steer, cfg_mirror.steer_limit);
        rng = quarter_hypot(s.pos_x, s.pos_y);
        spd = quarter_hypot(s.vel_x, s.vel_y);
        drive = (longint'(cfg_mirror.drive_gain_p) * (longint'(s.wanted_depth) * 4 - rng))
                / 16384;
        drive += (-longint'(cfg_mirror.drive_gain_d) * spd * 4) / 16384;
        drive = clamp_bias(drive, cfg_mirror.drive_limit);
        r.result_valid = 1'b1;
        r.steer_corr   = steer[15:0];
        r.drive_corr   = drive[15:0];
        r.target_range = rng[15:0];
        r.target_speed = spd[15:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic signed [17:0] rand_s18();
        int t;
        t = $urandom_range(0, 600);
        case ($urandom_range(0, 9))
            0:       return -18'sd131072;
            1:       return 18'sd131071;
            2:       return -18'sd131071;
            3, 4:    return 18'(t - 300);
            default: return 18'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] rand_s16();
        int t;
        t = $urandom_range(0, 600);
        case ($urandom_range(0, 9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3:    return 16'(t - 300);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [14:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return 15'd0;
            1:       return 15'd32767;
            2, 3:    return 15'($urandom_range(0, 1000));
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic sample_t make_sample(input logic v, input int ang, input int rate,
                                            input int px, input int py, input int vx,
                                            input int vy, input int depth, input logic gp,
                                            input int gyro);
        sample_t s;
        s = '{v, 18'(ang), 18'(rate), 18'(px), 18'(py), 18'(vx), 18'(vy), 16'(depth),
              gp, 16'(gyro)};
        return s;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.target_valid = ($urandom_range(0, 7) != 0);
        s.target_angle = rand_s18();
        s.angle_rate   = rand_s18();
        s.pos_x        = rand_s18();
        s.pos_y        = rand_s18();
        s.vel_x        = rand_s18();
        s.vel_y        = rand_s18();
        s.wanted_depth = rand_s16();
        s.gyro_present = 1'($urandom_range(0, 1));
        s.gyro_rate    = rand_s16();
        return s;
    endfunction

    function automatic bias_cfg_t random_config();
        bias_cfg_t c;
        c.steer_gain_p = rand_s16();
        c.steer_gain_d = rand_s16();
        c.steer_limit  = rand_limit();
        c.yaw_damp     = rand_s16();
        c.drive_gain_p = rand_s16();
        c.drive_gain_d = rand_s16();
        c.drive_limit  = rand_limit();
        return c;
    endfunction

    // ---------------------------------------------------------------- drivers

    // called and returns at a falling edge; cfg_we is low again on return
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_STEER_GAIN_P: cfg_mirror.steer_gain_p = data;
            REG_STEER_GAIN_D: cfg_mirror.steer_gain_d = data;
            REG_STEER_LIMIT:  cfg_mirror.steer_limit  = data[14:0];
            REG_YAW_DAMP:     cfg_mirror.yaw_damp     = data;
            REG_DRIVE_GAIN_P: cfg_mirror.drive_gain_p = data;
            REG_DRIVE_GAIN_D: cfg_mirror.drive_gain_d = data;
            REG_DRIVE_LIMIT:  cfg_mirror.drive_limit  = data[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // the unused top bit of each limit word gets a random value, it must be dropped
    task automatic cfg_apply(input bias_cfg_t c);
        cfg_write(REG_STEER_GAIN_P, c.steer_gain_p);
        cfg_write(REG_STEER_GAIN_D, c.steer_gain_d);
        cfg_write(REG_STEER_LIMIT, {1'($urandom_range(0, 1)), c.steer_limit});
        cfg_write(REG_YAW_DAMP, c.yaw_damp);
        cfg_write(REG_DRIVE_GAIN_P, c.drive_gain_p);
        cfg_write(REG_DRIVE_GAIN_D, c.drive_gain_d);
        cfg_write(REG_DRIVE_LIMIT, {1'($urandom_range(0, 1)), c.drive_limit});
    endtask

    // called and returns at a falling edge; in_valid stays high on return, so the
    // caller either sends the next word right away or drops valid
    task automatic send_sample(input sample_t s);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        target_valid <= s.target_valid;
        target_angle <= s.target_angle;
        angle_rate   <= s.angle_rate;
        pos_x        <= s.pos_x;
        pos_y        <= s.pos_y;
        vel_x        <= s.vel_x;
        vel_y        <= s.vel_y;
        wanted_depth <= s.wanted_depth;
        gyro_present <= s.gyro_present;
        gyro_rate    <= s.gyro_rate;
        do
            @(posedge clk);
        while (in_stall);
        bias_q.push_back(predict_bias(s));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (bias_q.size() == 0);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(random_sample());
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input longint want, input longint got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        bias_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bias_q.size() == 0)
            begin
                $error("word with no expectation: steer %0d drive %0d range %0d speed %0d",
                       steer_corr, drive_corr, target_range, target_speed);
                fail_count++;
            end
            else
            begin
                want = bias_q.pop_front();
                check_field("result_valid", longint'(want.result_valid),
                            longint'(result_valid));
                check_field("steer_corr", longint'(want.steer_corr), longint'(steer_corr));
                check_field("drive_corr", longint'(want.drive_corr), longint'(drive_corr));
                check_field("target_range", longint'(want.target_range),
                            longint'(target_range));
                check_field("target_speed", longint'(want.target_speed),
                            longint'(target_speed));
            end
            if ($urandom_range(0, 29) == 0)
                recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : $urandom_range(0, 7);
        end
    end

    // receiver holds stall after each word until the drawn stall_left count runs out
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // reset values of every register, field extremes, invalid target
    task automatic test_reset_defaults();
        send_sample(make_sample(0, 131071, -131072, 131071, -131072, 5000, -5000, 32767,
                                1, -32768));
        send_sample(make_sample(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // most negative coordinates give the largest root, 46340
        send_sample(make_sample(1, -131072, 131071, -131072, -131072, -131072, -131072,
                                -32768, 1, 32767));
        send_sample(make_sample(1, 131071, -131072, 131071, 131071, 131071, 131071, 32767,
                                0, -32768));
        // small negatives: quarters and quotients round toward zero
        send_sample(make_sample(1, -3, 5, -3, 7, -5, -1, 1, 1, -1));
        send_sample(make_sample(1, 1000, -2000, 40000, -30000, -7, 9, 12500, 1, 100));
        wait_drained();
    endtask

    // largest negative gains with open limits, then max gains with zero limits
    task automatic test_gain_extremes();
        cfg_apply('{-16'sd32768, -16'sd32768, 15'd32767, -16'sd32768, -16'sd32768,
                    -16'sd32768, 15'd32767});
        send_sample(make_sample(1, -131072, -131072, -131072, -131072, -131072, -131072,
                                -32768, 1, -32768));
        send_sample(make_sample(1, 131071, 131071, 131071, 131071, 131071, 131071, 32767,
                                1, 32767));
        send_sample(make_sample(1, 517, -913, 1234, -4321, 77, -99, -300, 1, -45));
        send_sample(make_sample(1, 517, -913, 1234, -4321, 77, -99, -300, 0, -45));
        wait_drained();
        cfg_apply('{16'sd32767, 16'sd32767, 15'd0, 16'sd32767, 16'sd32767, 16'sd32767,
                    15'd0});
        send_sample(make_sample(1, -131072, 131071, 2000, -2000, 3000, 400, 32767, 1,
                                32767));
        send_sample(make_sample(1, 4, -4, 4, -4, 4, -4, -1, 1, 1));
        wait_drained();
        // unit gains show truncation of negative quotients
        cfg_apply('{-16'sd1, 16'sd1, 15'd32767, 16'sd1, -16'sd1, 16'sd1, 15'd32767});
        send_sample(make_sample(1, 16385, -16385, 8, -8, -12, 12, -5, 1, -1025));
        send_sample(make_sample(1, -16383, 16383, -131072, 0, 0, -131072, 5, 1, 1023));
        wait_drained();
    endtask

    // a write to an index with no register leaves every register unchanged
    task automatic test_unknown_register();
        cfg_write(REG_UNUSED, 16'($urandom()));
        send_sample(make_sample(1, 3000, -3000, 9000, 12000, -800, 600, 4000, 1, 2000));
        send_sample(make_sample(1, -70000, 70000, -9000, 12000, 800, -600, -4000, 1, -2000));
        wait_drained();
    endtask

    task automatic test_random_phases();
        cfg_apply('{STEER_GAIN_P_RST, STEER_GAIN_D_RST, STEER_LIMIT_RST, YAW_DAMP_RST,
                    DRIVE_GAIN_P_RST, DRIVE_GAIN_D_RST, DRIVE_LIMIT_RST});
        send_random(60);
        wait_drained();
        for (int phase = 0; phase < 5; phase++)
        begin
            cfg_apply(random_config());
            send_random(60);
            wait_drained();
        end
    endtask

    // sender holds off mid-stream until the pipe is empty, then resumes
    task automatic test_drain_pause();
        cfg_apply(random_config());
        send_random(45);
        wait_drained();
        send_random(45);
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        target_valid = 1'b0;
        target_angle = '0;
        angle_rate   = '0;
        pos_x        = '0;
        pos_y        = '0;
        vel_x        = '0;
        vel_y        = '0;
        wanted_depth = '0;
        gyro_present = 1'b0;
        gyro_rate    = '0;
        fail_count   = 0;
        stall_left   = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        cfg_mirror   = '{STEER_GAIN_P_RST, STEER_GAIN_D_RST, STEER_LIMIT_RST, YAW_DAMP_RST,
                         DRIVE_GAIN_P_RST, DRIVE_GAIN_D_RST, DRIVE_LIMIT_RST};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_gain_extremes();
        test_unknown_register();
        test_random_phases();
        test_drain_pause();

        wait_drained();
        // any stray word after the last expected one is caught by the checker
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
